>>> design/dtes_pkg.sv
// dtes_pkg: constants and small decode functions for the date-to-epoch pipeline.
// Used by datetime_to_epoch_seconds; depends on nothing else.
`default_nettype none

package dtes_pkg;

  // Field widths inside the pipeline
  localparam int unsigned YEAR_W = 16;
  localparam int unsigned DAYS_W = 25;  // largest day count is about 23.2e6
  localparam int unsigned TSEC_W = 22;  // signed h/m/s/tz seconds
  localparam int unsigned PROD_W = 42;  // days * 86400 plus seconds
  localparam int unsigned Q100_W = 10;  // floor(65535 / 100) = 655
  localparam int unsigned TZ_W   = 12;  // offset within +/-1440, else zero

  localparam logic [15:0] BASE_YEAR    = 16'd2016;
  localparam logic [24:0] BASE_DAYS_M1 = 25'd16800;  // base day minus one for day-of-month
  localparam logic [24:0] LEAPS_2015   = 25'd488;    // 2015/4 - 2015/100 + 2015/400
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic signed [15:0] TZ_LIMIT = 16'sd1440;

  // n / 100 for any 16-bit n: (n * 83887) >> 23
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam int unsigned RECIP_SHIFT = 23;

  localparam logic [3:0] MONTH_MAX = 4'd13;

  // Two BCD digits; a nibble above 9 keeps its plain weight
  function automatic logic [7:0] bcd2(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  // Days in the months before month m, February counted as zero
  function automatic logic [8:0] month_cum(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd31;
      4'd4:       r = 9'd62;
      4'd5:       r = 9'd92;
      4'd6:       r = 9'd123;
      4'd7:       r = 9'd153;
      4'd8:       r = 9'd184;
      4'd9:       r = 9'd215;
      4'd10:      r = 9'd245;
      4'd11:      r = 9'd276;
      4'd12:      r = 9'd306;
      4'd13:      r = 9'd337;
      default:    r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/datetime_to_epoch_seconds.sv
// datetime_to_epoch_seconds: five-stage pipeline from seven date bytes and a
// timezone offset to UTC epoch seconds. Depends on dtes_pkg.
// Throughput: one word per cycle while the output is taken; each stage advances
// on its own, so bubbles close up while a result waits on the output register.
// Reset: rst_ni clears only the stage valid bits; payload registers are not reset.
`default_nettype none

module datetime_to_epoch_seconds import dtes_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         date_byte0_i,
  input  wire logic [7:0]         date_byte1_i,
  input  wire logic [7:0]         date_byte2_i,
  input  wire logic [7:0]         date_byte3_i,
  input  wire logic [7:0]         date_byte4_i,
  input  wire logic [7:0]         date_byte5_i,
  input  wire logic [7:0]         date_byte6_i,
  input  wire logic signed [15:0] tz_minutes_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [63:0]             utc_seconds_o,
  output logic                    was_bcd_o,
  output logic                    month_clamped_o
);

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or the stage after it loads.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick BCD or binary reading, clamp month, zero an out-of-range timezone.
  // ---------------------------------------------------------------------------
  logic                bcd_d;
  logic [YEAR_W-1:0]   year_d;
  logic [7:0]          mon_raw;
  logic [3:0]          mon_d;
  logic                clamp_d;
  logic [7:0]          day_d, hour_d, min_d, sec_d;
  logic                tz_ok;
  logic [TZ_W-1:0]     tz_d;

  always_comb begin
    bcd_d = date_byte0_i >= 8'h20 && date_byte0_i <= 8'h30 && date_byte1_i <= 8'h99 &&
            date_byte2_i >= 8'h01 && date_byte2_i <= 8'h12 &&
            date_byte3_i >= 8'h01 && date_byte3_i <= 8'h31 &&
            date_byte4_i <= 8'h23 && date_byte5_i <= 8'h59 && date_byte6_i <= 8'h60;
    if (bcd_d) begin
      year_d  = 16'(date_byte0_i[7:4]) * 16'd1000 + 16'(date_byte0_i[3:0]) * 16'd100
              + 16'(bcd2(date_byte1_i));
      mon_raw = bcd2(date_byte2_i);
      day_d   = bcd2(date_byte3_i);
      hour_d  = bcd2(date_byte4_i);
      min_d   = bcd2(date_byte5_i);
      sec_d   = bcd2(date_byte6_i);
    end else begin
      year_d  = {date_byte1_i, date_byte0_i};
      mon_raw = date_byte2_i;
      day_d   = date_byte3_i;
      hour_d  = date_byte4_i;
      min_d   = date_byte5_i;
      sec_d   = date_byte6_i;
    end
    // A month past 13 would run off the month table: hold it at a full year
    clamp_d = mon_raw > 8'(MONTH_MAX);
    mon_d   = clamp_d ? MONTH_MAX : mon_raw[3:0];
    // Drop an offset beyond a full day
    tz_ok   = tz_minutes_i >= -TZ_LIMIT && tz_minutes_i <= TZ_LIMIT;
    tz_d    = tz_ok ? tz_minutes_i[TZ_W-1:0] : '0;
  end

  logic                s1_bcd_q, s1_clamp_q;
  logic [YEAR_W-1:0]   s1_year_q;
  logic [3:0]          s1_mon_q;
  logic [7:0]          s1_day_q, s1_hour_q, s1_min_q, s1_sec_q;
  logic [TZ_W-1:0]     s1_tz_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_bcd_q   <= bcd_d;
      s1_clamp_q <= clamp_d;
      s1_year_q  <= year_d;
      s1_mon_q   <= mon_d;
      s1_day_q   <= day_d;
      s1_hour_q  <= hour_d;
      s1_min_q   <= min_d;
      s1_sec_q   <= sec_d;
      s1_tz_q    <= tz_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide year and year-1 by 100, days of whole years, time of day.
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0]   yprev;
  logic [32:0]         py_prod, pn_prod;
  logic                ygt_d;
  logic [DAYS_W-1:0]   ydays_d;
  logic [12:0]         tzmin;
  logic [TSEC_W-1:0]   tsec_d;

  always_comb begin
    yprev   = s1_year_q - 16'd1;
    py_prod = 33'(s1_year_q) * 33'(RECIP_100);
    pn_prod = 33'(yprev) * 33'(RECIP_100);
    ygt_d   = s1_year_q > BASE_YEAR;
    ydays_d = ygt_d ? 25'(s1_year_q - BASE_YEAR) * 25'd365 : '0;
    // Offset minutes plus minute field, signed; fits 13 bits
    tzmin   = {s1_tz_q[TZ_W-1], s1_tz_q} + {5'b0, s1_min_q};
    tsec_d  = 22'(s1_hour_q) * 22'd3600
            + {{(TSEC_W-13){tzmin[12]}}, tzmin} * 22'd60
            + 22'(s1_sec_q);
  end

  logic                s2_bcd_q, s2_clamp_q, s2_ygt_q;
  logic [YEAR_W-1:0]   s2_year_q, s2_yprev_q;
  logic [Q100_W-1:0]   s2_qy_q, s2_qn_q;
  logic [DAYS_W-1:0]   s2_ydays_q;
  logic [3:0]          s2_mon_q;
  logic [7:0]          s2_day_q;
  logic [TSEC_W-1:0]   s2_tsec_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_bcd_q   <= s1_bcd_q;
      s2_clamp_q <= s1_clamp_q;
      s2_ygt_q   <= ygt_d;
      s2_year_q  <= s1_year_q;
      s2_yprev_q <= yprev;
      s2_qy_q    <= py_prod[RECIP_SHIFT +: Q100_W];
      s2_qn_q    <= pn_prod[RECIP_SHIFT +: Q100_W];
      s2_ydays_q <= ydays_d;
      s2_mon_q   <= s1_mon_q;
      s2_day_q   <= s1_day_q;
      s2_tsec_q  <= tsec_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: leap count, leap year test, month days, total day number.
  // ---------------------------------------------------------------------------
  logic [13:0]         leaps_n;
  logic                div100, leap;
  logic [8:0]          feb;
  logic [DAYS_W-1:0]   lterm, days_d;

  always_comb begin
    leaps_n = 14'(s2_yprev_q >> 2) - 14'(s2_qn_q) + 14'(s2_qn_q >> 2);
    div100  = 17'(s2_year_q) == 17'(s2_qy_q) * 17'd100;
    // Century years are leap only when the century count divides by four
    leap    = s2_year_q[1:0] == 2'b00 && !(div100 && s2_qy_q[1:0] != 2'b00);
    feb     = (s2_mon_q >= 4'd3) ? (leap ? 9'd29 : 9'd28) : 9'd0;
    lterm   = s2_ygt_q ? 25'(leaps_n) - LEAPS_2015 : '0;
    days_d  = BASE_DAYS_M1 + s2_ydays_q + lterm + 25'(month_cum(s2_mon_q)) + 25'(feb)
            + 25'(s2_day_q);
  end

  logic                s3_bcd_q, s3_clamp_q;
  logic [DAYS_W-1:0]   s3_days_q;
  logic [TSEC_W-1:0]   s3_tsec_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_bcd_q   <= s2_bcd_q;
      s3_clamp_q <= s2_clamp_q;
      s3_days_q  <= days_d;
      s3_tsec_q  <= s2_tsec_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: days to seconds.
  // ---------------------------------------------------------------------------
  logic                s4_bcd_q, s4_clamp_q;
  logic [PROD_W-1:0]   s4_prod_q;
  logic [TSEC_W-1:0]   s4_tsec_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_bcd_q   <= s3_bcd_q;
      s4_clamp_q <= s3_clamp_q;
      s4_prod_q  <= 42'(s3_days_q) * 42'(SECS_PER_DAY);
      s4_tsec_q  <= s3_tsec_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: add the signed time of day into the output register. The total
  // never goes negative since the day count starts near 16800.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]   sum_d;
  logic                s5_bcd_q, s5_clamp_q;
  logic [PROD_W-1:0]   s5_utc_q;

  assign sum_d = s4_prod_q + {{(PROD_W-TSEC_W){s4_tsec_q[TSEC_W-1]}}, s4_tsec_q};

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_bcd_q   <= s4_bcd_q;
      s5_clamp_q <= s4_clamp_q;
      s5_utc_q   <= sum_d;
    end
  end

  assign out_valid_o     = v5_q;
  assign utc_seconds_o   = 64'(s5_utc_q);
  assign was_bcd_o       = s5_bcd_q;
  assign month_clamped_o = s5_clamp_q;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// tb_top: self-checking bench for datetime_to_epoch_seconds (date bytes plus timezone to UTC
// epoch seconds). Drives directed and random words through valid/ready with random idling
// and checks each output against a calendar predictor or pinned result. Needs only the RTL.
`timescale 1ns / 100ps

module tb_top;

  // One input word: seven date bytes and a signed timezone offset in minutes
  typedef struct packed {
    logic [7:0]         date_byte0;
    logic [7:0]         date_byte1;
    logic [7:0]         date_byte2;
    logic [7:0]         date_byte3;
    logic [7:0]         date_byte4;
    logic [7:0]         date_byte5;
    logic [7:0]         date_byte6;
    logic signed [15:0] tz_minutes;
  } date_word_t;

  typedef struct packed {
    logic [63:0] utc_seconds;
    logic        was_bcd;
    logic        month_clamped;
  } epoch_result_t;

  // Directed row: pinned rows carry a hand-derived result, the rest go to the predictor
  typedef struct packed {
    date_word_t    word;
    logic          pinned;
    epoch_result_t result;
  } directed_row_t;

  localparam logic [63:0]        BASE_DAY  = 64'd16801;   // 2016-01-01 as a day number
  localparam logic [63:0]        BASE_YEAR = 64'd2016;
  localparam logic signed [15:0] TZ_SPAN   = 16'sd1440;
  localparam int                 MONTH_DAYS [12] = '{31, 0, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam epoch_result_t PREDICT = '{64'd0, 1'b0, 1'b0};

  localparam int N_DIRECTED = 25;
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // all zero: binary decode, month zero, day zero wraps back one day
    '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b1,
      '{64'd1451520000, 1'b0, 1'b0}},
    // 2016-01-01 00:00:00 in BCD lands exactly on the base day
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b1,
      '{64'd1451606400, 1'b1, 1'b0}},
    // year before the base adds no years
    '{'{8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b1,
      '{64'd1451606400, 1'b1, 1'b0}},
    // timezone at both limits, just outside them, and at the field extremes
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd1440}, 1'b1,
      '{64'd1451692800, 1'b1, 1'b0}},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, -16'sd1440}, 1'b1,
      '{64'd1451520000, 1'b1, 1'b0}},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd1441}, 1'b1,
      '{64'd1451606400, 1'b1, 1'b0}},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, -16'sd1441}, 1'b1,
      '{64'd1451606400, 1'b1, 1'b0}},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sh8000}, 1'b1,
      '{64'd1451606400, 1'b1, 1'b0}},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sh7FFF}, 1'b1,
      '{64'd1451606400, 1'b1, 1'b0}},
    // binary month 14 clamps to a full leap year of months (year 0 is leap)
    '{'{8'h00, 8'h00, 8'h0E, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b1,
      '{64'd1483228800, 1'b0, 1'b1}},
    // all ones with a small negative offset
    '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, -16'sd1}, 1'b0, PREDICT},
    // every BCD field at its upper bound
    '{'{8'h30, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h60, 16'sd1440}, 1'b0, PREDICT},
    // non-decimal nibbles that still pass the BCD test, month reads as 15
    '{'{8'h20, 8'h16, 8'h0F, 8'h1F, 8'h1F, 8'h3F, 8'h5F, 16'sd0}, 1'b0, PREDICT},
    // one byte just outside its BCD range each: falls back to binary
    '{'{8'h1F, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h31, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h9A, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h16, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h16, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h16, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h16, 8'h01, 8'h32, 8'h00, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h24, 8'h00, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h5A, 8'h00, 16'sd0}, 1'b0, PREDICT},
    '{'{8'h20, 8'h16, 8'h01, 8'h01, 8'h00, 8'h00, 8'h61, 16'sd0}, 1'b0, PREDICT},
    // binary 2100-03-01: century year without a leap day
    '{'{8'h34, 8'h08, 8'h03, 8'h01, 8'h0C, 8'h1E, 8'h2D, 16'sd60}, 1'b0, PREDICT},
    // binary 2000-03-01: before the base, but February still leap
    '{'{8'hD0, 8'h07, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, -16'sd60}, 1'b0, PREDICT}
  };

  localparam int WORDS_PER_PHASE = 110;
  localparam int HOLD_OFF_CYCLES = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         date_byte0_i;
  logic [7:0]         date_byte1_i;
  logic [7:0]         date_byte2_i;
  logic [7:0]         date_byte3_i;
  logic [7:0]         date_byte4_i;
  logic [7:0]         date_byte5_i;
  logic [7:0]         date_byte6_i;
  logic signed [15:0] tz_minutes_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [63:0]        utc_seconds_o;
  logic               was_bcd_o;
  logic               month_clamped_o;

  // Expected epochs in acceptance order, and the run's error tally
  epoch_result_t pending_epochs [$];
  epoch_result_t oldest_epoch;
  int            mismatch_count = 0;

  // Idle odds in percent, and the length of a forced receiver hold-off
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  datetime_to_epoch_seconds uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .date_byte0_i    (date_byte0_i),
    .date_byte1_i    (date_byte1_i),
    .date_byte2_i    (date_byte2_i),
    .date_byte3_i    (date_byte3_i),
    .date_byte4_i    (date_byte4_i),
    .date_byte5_i    (date_byte5_i),
    .date_byte6_i    (date_byte6_i),
    .tz_minutes_i    (tz_minutes_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .utc_seconds_o   (utc_seconds_o),
    .was_bcd_o       (was_bcd_o),
    .month_clamped_o (month_clamped_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Weight two nibbles as tens and units; nibbles above 9 keep their plain value
  function automatic logic [63:0] bcd_value(input logic [7:0] b);
    return 64'(b[7:4]) * 10 + 64'(b[3:0]);
  endfunction

  // Leap days in years 1..n under the Gregorian rule
  function automatic logic [63:0] leaps_through(input logic [63:0] n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic logic leap_year(input logic [63:0] y);
    return (y[1:0] == 2'b00) && !((y % 100 == 0) && (y % 400 != 0));
  endfunction

  // Work out the epoch for one word; all sums wrap at 64 bits
  function automatic epoch_result_t predict_epoch(input date_word_t w);
    logic [63:0]        yr, mon, dom, hr, mnt, sec, days, tz_off;
    logic signed [15:0] tz;
    logic               decimal;
    int                 j;
    epoch_result_t      res;
    decimal = w.date_byte0 >= 8'h20 && w.date_byte0 <= 8'h30 && w.date_byte1 <= 8'h99 &&
              w.date_byte2 >= 8'h01 && w.date_byte2 <= 8'h12 &&
              w.date_byte3 >= 8'h01 && w.date_byte3 <= 8'h31 &&
              w.date_byte4 <= 8'h23 && w.date_byte5 <= 8'h59 && w.date_byte6 <= 8'h60;
    if (decimal) begin
      yr  = 64'(w.date_byte0[7:4]) * 1000 + 64'(w.date_byte0[3:0]) * 100 +
            bcd_value(w.date_byte1);
      mon = bcd_value(w.date_byte2);
      dom = bcd_value(w.date_byte3);
      hr  = bcd_value(w.date_byte4);
      mnt = bcd_value(w.date_byte5);
      sec = bcd_value(w.date_byte6);
    end else begin
      yr  = {48'd0, w.date_byte1, w.date_byte0};
      mon = 64'(w.date_byte2);
      dom = 64'(w.date_byte3);
      hr  = 64'(w.date_byte4);
      mnt = 64'(w.date_byte5);
      sec = 64'(w.date_byte6);
    end
    res.was_bcd       = decimal;
    res.month_clamped = (mon > 13);
    if (mon > 13) mon = 13;

    tz = w.tz_minutes;
    if (tz < -TZ_SPAN || tz > TZ_SPAN) tz = '0;
    tz_off = {{48{tz[15]}}, tz};

    days = BASE_DAY;
    if (yr > BASE_YEAR)
      days += 365 * (yr - BASE_YEAR) + leaps_through(yr - 1) - leaps_through(BASE_YEAR - 1);
    for (j = 1; j < mon; j++)
      days += (j == 2) ? (leap_year(yr) ? 29 : 28) : MONTH_DAYS[j - 1];
    days += dom - 1;   // day zero wraps the whole sum

    res.utc_seconds = days * 86400 + hr * 3600 + (tz_off + mnt) * 60 + sec;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly well-formed dates: half BCD-shaped (raw bytes inside every BCD range,
  // odd nibbles included), a third binary calendar dates, the rest raw noise
  function automatic date_word_t random_word();
    date_word_t  w;
    int unsigned kind, yr;
    kind = $urandom_range(99);
    if (kind < 50) begin
      w.date_byte0 = 8'($urandom_range(8'h20, 8'h30));
      w.date_byte1 = 8'($urandom_range(8'h00, 8'h99));
      w.date_byte2 = 8'($urandom_range(8'h01, 8'h12));
      w.date_byte3 = 8'($urandom_range(8'h01, 8'h31));
      w.date_byte4 = 8'($urandom_range(8'h00, 8'h23));
      w.date_byte5 = 8'($urandom_range(8'h00, 8'h59));
      w.date_byte6 = 8'($urandom_range(8'h00, 8'h60));
    end else if (kind < 85) begin
      yr = (kind < 80) ? $urandom_range(1960, 2400) : $urandom_range(0, 65535);
      {w.date_byte1, w.date_byte0} = 16'(yr);
      w.date_byte2 = 8'($urandom_range(0, 15));
      w.date_byte3 = 8'($urandom_range(0, 31));
      w.date_byte4 = 8'($urandom_range(0, 23));
      w.date_byte5 = 8'($urandom_range(0, 59));
      w.date_byte6 = 8'($urandom_range(0, 60));
    end else begin
      {w.date_byte0, w.date_byte1, w.date_byte2, w.date_byte3} = $urandom;
      {w.date_byte4, w.date_byte5, w.date_byte6} = 24'($urandom);
    end

    // Offset: mostly in range, some at or just past the limits, some anywhere
    kind = $urandom_range(9);
    if (kind < 6) begin
      w.tz_minutes = 16'(int'($urandom_range(0, 2880)) - 1440);
    end else if (kind < 7) begin
      case ($urandom_range(3))
        0:       w.tz_minutes = TZ_SPAN;
        1:       w.tz_minutes = -TZ_SPAN;
        2:       w.tz_minutes = TZ_SPAN + 16'sd1;
        default: w.tz_minutes = -TZ_SPAN - 16'sd1;
      endcase
    end else begin
      w.tz_minutes = 16'($urandom);
    end
    return w;
  endfunction

  // Offer one word: idle at random, raise valid with the payload, hold until the
  // handshake, then log what the block owes us. Valid stays up between back-to-back
  // words so it is never dropped and raised in the same step.
  task automatic send_word(input date_word_t w, input epoch_result_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    date_byte0_i <= w.date_byte0;
    date_byte1_i <= w.date_byte1;
    date_byte2_i <= w.date_byte2;
    date_byte3_i <= w.date_byte3;
    date_byte4_i <= w.date_byte4;
    date_byte5_i <= w.date_byte5;
    date_byte6_i <= w.date_byte6;
    tz_minutes_i <= w.tz_minutes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_epochs.push_back(want);
  endtask

  // Receiver: honor a pending hold-off first, otherwise stall at the phase's odds
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Output check: compare each accepted word with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_epochs.size() == 0) begin
        $error("unexpected output word: utc_seconds %0d was_bcd %0b month_clamped %0b",
               utc_seconds_o, was_bcd_o, month_clamped_o);
        mismatch_count++;
      end else begin
        oldest_epoch = pending_epochs.pop_front();
        if (utc_seconds_o !== oldest_epoch.utc_seconds) begin
          $error("utc_seconds: expected %0d, got %0d", oldest_epoch.utc_seconds, utc_seconds_o);
          mismatch_count++;
        end
        if (was_bcd_o !== oldest_epoch.was_bcd) begin
          $error("was_bcd: expected %0b, got %0b", oldest_epoch.was_bcd, was_bcd_o);
          mismatch_count++;
        end
        if (month_clamped_o !== oldest_epoch.month_clamped) begin
          $error("month_clamped: expected %0b, got %0b",
                 oldest_epoch.month_clamped, month_clamped_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed table, then random phases with different idling
  // ---------------------------------------------------------------------------
  initial begin
    date_word_t w;
    int         drain;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_ready_i  = 1'b0;
    date_byte0_i = '0;
    date_byte1_i = '0;
    date_byte2_i = '0;
    date_byte3_i = '0;
    date_byte4_i = '0;
    date_byte5_i = '0;
    date_byte6_i = '0;
    tz_minutes_i = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table back to back; pinned rows bring their own answer
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_word(DIRECTED_ROWS[r].word,
                DIRECTED_ROWS[r].pinned ? DIRECTED_ROWS[r].result
                                        : predict_epoch(DIRECTED_ROWS[r].word));
    end

    // Phases: no idling, sender idle, receiver stalls, both, then a long
    // hold-off against a full-rate sender so the pipeline fills and backs up
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        3: begin send_idle_pct = 38; recv_stall_pct = 38; end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_left      = HOLD_OFF_CYCLES;
        end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        w = random_word();
        send_word(w, predict_epoch(w));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then watch a few more cycles for stray output words
    while (pending_epochs.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < 20; drain++) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("datetime_to_epoch_seconds: match");
    end else begin
      $display("datetime_to_epoch_seconds: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("datetime_to_epoch_seconds: mismatch");
    $finish;
  end

endmodule

>>> datetime_to_epoch_seconds.f
design/dtes_pkg.sv
design/datetime_to_epoch_seconds.sv
verif/tb_top.sv
